// ===== rtl/skf_pkg.sv =====
`timescale 1ns / 1ps

package skf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int GAIN_W    = FRAC_BITS;
	// counter spans the F+1 quotient bits of the divider
	localparam int CNT_W     = $clog2(FRAC_BITS + 2);
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_PROCESS_NOISE     = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_MEASUREMENT_NOISE = REG_IDX_W'(1);

	localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = DATA_W'(655);
	localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = DATA_W'(65536);
	localparam logic [DATA_W-1:0] COVARIANCE_RST        = DATA_W'(65536);

	typedef struct packed {
		logic load;
		logic step;
	} ctl_t;

endpackage

// ===== rtl/skf_div.sv =====
`timescale 1ns / 1ps

// Restoring radix-2 divider, one quotient bit per step, MSB first.
// Dividend is taken unscaled and the quotient is scaled by 2^F; it must not exceed the divisor.
module skf_div (
	input  logic                               clk,
	input  skf_pkg::ctl_t                      ctl,
	input  logic [skf_pkg::DATA_W-1:0]         dividend,
	input  logic [skf_pkg::DATA_W-1:0]         divisor,
	output logic [skf_pkg::FRAC_BITS:0]        quot
);

	logic [skf_pkg::DATA_W:0]   rem_q;
	logic [skf_pkg::DATA_W-1:0] dvs_q;
	logic [skf_pkg::FRAC_BITS:0] quo_q;
	logic [skf_pkg::DATA_W+1:0] sub;
	logic                       fit;
	logic [skf_pkg::DATA_W:0]   rsel;

	assign sub  = {1'b0, rem_q} - {2'b00, dvs_q};
	assign fit  = !sub[skf_pkg::DATA_W+1];
	assign rsel = fit ? sub[skf_pkg::DATA_W:0] : rem_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= {1'b0, dividend};
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (ctl.step) begin
			quo_q <= {quo_q[skf_pkg::FRAC_BITS-1:0], fit};
			// remainder stays below the divisor, so the top bit drops out
			rem_q <= {rsel[skf_pkg::DATA_W-1:0], 1'b0};
		end
	end

	assign quot = quo_q;

endmodule

// ===== rtl/skf_mul.sv =====
`timescale 1ns / 1ps

// Serial shift-add multiply, multiplier LSB first. Each step adds and shifts
// right, so after F steps the accumulator is floor(g * mcand / 2^F).
module skf_mul (
	input  logic                            clk,
	input  skf_pkg::ctl_t                   ctl,
	input  logic                            gbit,
	input  logic signed [skf_pkg::DATA_W:0] mcand,
	output logic signed [skf_pkg::DATA_W+2:0] acc
);

	logic signed [skf_pkg::DATA_W:0]   mcand_q;
	logic signed [skf_pkg::DATA_W+2:0] acc_q;
	logic signed [skf_pkg::DATA_W+2:0] sum;

	assign sum = acc_q + (gbit ? {{2{mcand_q[skf_pkg::DATA_W]}}, mcand_q}
	                           : {(skf_pkg::DATA_W+3){1'b0}});

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mcand_q <= mcand;
			acc_q   <= '0;
		end else if (ctl.step) begin
			acc_q <= {sum[skf_pkg::DATA_W+2], sum[skf_pkg::DATA_W+2:1]};
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/scalar_kalman_filter_core.sv =====
`timescale 1ns / 1ps

// Channel   | handshake                      | payload
// ----------+--------------------------------+-------------------------------
// sample    | sample_valid / sample_ready    | sample (s Q16.16)
// result    | result_valid / result_ready    | filtered, covariance_now
// config    | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// One sample at a time: the time from accept to result is set by the serial
// divider (F+1 steps) and the serial multipliers (F steps, both products in
// parallel). The next sample is taken the cycle after the result register is
// loaded. Reset restores Q, R, estimate and covariance at once. A stalled
// result holds the datapath in its last state.
module scalar_kalman_filter_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic [skf_pkg::DATA_W-1:0]           sample,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [skf_pkg::DATA_W-1:0]           filtered,
	output logic [skf_pkg::DATA_W-1:0]           covariance_now,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [skf_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [skf_pkg::DATA_W-1:0]           cfg_data
);

	localparam int W = skf_pkg::DATA_W;
	localparam int F = skf_pkg::FRAC_BITS;
	localparam logic [skf_pkg::CNT_W-1:0] DIV_LAST = skf_pkg::CNT_W'(F);
	localparam logic [skf_pkg::CNT_W-1:0] MUL_LAST = skf_pkg::CNT_W'(F - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEN,
		S_DIV,
		S_GAIN,
		S_MUL,
		S_UPD,
		S_OUT
	} state_t;

	state_t                    state_q;
	logic [skf_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0]              q_noise_q;
	logic [W-1:0]              r_noise_q;
	logic [W-1:0]              est_q;
	logic [W-1:0]              cov_q;
	logic [W-1:0]              sample_q;
	logic [W-1:0]              pp_q;
	logic                      den_zero_q;
	logic [skf_pkg::GAIN_W-1:0] g_q;
	logic                      out_valid_q;
	logic [W-1:0]              filtered_q;
	logic [W-1:0]              cov_out_q;

	logic [W:0]                pp_sum;
	logic [W-1:0]              pp_sat;
	logic [W:0]                den_sum;
	logic [W-1:0]              den_sat;
	logic [F:0]                quot;
	logic [skf_pkg::GAIN_W-1:0] gain;
	logic signed [W:0]         diff;
	logic signed [W:0]         neg_pp;
	logic signed [W+2:0]       acc_e;
	logic signed [W+2:0]       acc_c;
	logic [W+3:0]              nx;
	logic [W-1:0]              nx_sat;
	logic [W-1:0]              cov_new;
	logic                      accept;
	logic                      out_free;
	skf_pkg::ctl_t             div_ctl;
	skf_pkg::ctl_t             mul_ctl;

	assign accept   = sample_valid && sample_ready;
	assign out_free = !out_valid_q || result_ready;

	assign pp_sum  = {1'b0, cov_q} + {1'b0, q_noise_q};
	assign pp_sat  = pp_sum[W] ? '1 : pp_sum[W-1:0];
	assign den_sum = {1'b0, pp_q} + {1'b0, r_noise_q};
	assign den_sat = den_sum[W] ? '1 : den_sum[W-1:0];

	// quotient of exactly 1.0 saturates to the largest Q0.F gain
	assign gain = den_zero_q ? '0 : (quot[F] ? '1 : quot[F-1:0]);

	assign diff   = {sample_q[W-1], sample_q} - {est_q[W-1], est_q};
	assign neg_pp = {(W+1){1'b0}} - {1'b0, pp_q};

	assign div_ctl.load = (state_q == S_DEN);
	assign div_ctl.step = (state_q == S_DIV);
	assign mul_ctl.load = (state_q == S_GAIN);
	assign mul_ctl.step = (state_q == S_MUL);

	skf_div u_div (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (pp_q),
		.divisor  (den_sat),
		.quot     (quot)
	);

	skf_mul u_mul_est (
		.clk   (clk),
		.ctl   (mul_ctl),
		.gbit  (g_q[0]),
		.mcand (diff),
		.acc   (acc_e)
	);

	// (1 - g) * pp computed as pp + floor(g * -pp / 2^F)
	skf_mul u_mul_cov (
		.clk   (clk),
		.ctl   (mul_ctl),
		.gbit  (g_q[0]),
		.mcand (neg_pp),
		.acc   (acc_c)
	);

	assign nx = {{4{est_q[W-1]}}, est_q} + {acc_e[W+2], acc_e};

	always_comb begin
		nx_sat = nx[W-1:0];
		if (!nx[W+3] && (nx[W+2:W-1] != 4'b0000)) begin
			nx_sat = {1'b0, {(W-1){1'b1}}};
		end else if (nx[W+3] && (nx[W+2:W-1] != 4'b1111)) begin
			nx_sat = {1'b1, {(W-1){1'b0}}};
		end
	end

	assign cov_new = pp_q + acc_c[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			q_noise_q   <= skf_pkg::PROCESS_NOISE_RST;
			r_noise_q   <= skf_pkg::MEASUREMENT_NOISE_RST;
			est_q       <= '0;
			cov_q       <= skf_pkg::COVARIANCE_RST;
			sample_q    <= '0;
			pp_q        <= '0;
			den_zero_q  <= 1'b0;
			g_q         <= '0;
			out_valid_q <= 1'b0;
			filtered_q  <= '0;
			cov_out_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					skf_pkg::REG_PROCESS_NOISE:     q_noise_q <= cfg_data;
					skf_pkg::REG_MEASUREMENT_NOISE: r_noise_q <= cfg_data;
					default: ;
				endcase
			end

			// in S_OUT the output step below owns the valid flag
			if (out_valid_q && result_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						sample_q <= sample;
						pp_q     <= pp_sat;
						state_q  <= S_DEN;
					end
				end
				S_DEN: begin
					den_zero_q <= (den_sat == '0);
					cnt_q      <= '0;
					state_q    <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_GAIN;
					end
				end
				S_GAIN: begin
					g_q     <= gain;
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					g_q   <= {1'b0, g_q[skf_pkg::GAIN_W-1:1]};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MUL_LAST) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					est_q   <= nx_sat;
					cov_q   <= cov_new;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						filtered_q  <= est_q;
						cov_out_q   <= cov_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample_ready   = (state_q == S_IDLE);
	assign cfg_ready      = 1'b1;
	assign result_valid   = out_valid_q;
	assign filtered       = filtered_q;
	assign covariance_now = cov_out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample_ready)
		else $error("sample taken while a request is in flight");

	a_cov_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> (cov_new <= pp_q))
		else $error("updated covariance exceeds prediction");

	a_zero_den_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GAIN && den_zero_q) |-> (gain == '0))
		else $error("nonzero gain with zero divisor");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output step");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int FRAC_BITS = skf_pkg::FRAC_BITS;
	localparam int DATA_W    = skf_pkg::DATA_W;
	localparam int REG_IDX_W = skf_pkg::REG_IDX_W;
	localparam logic [REG_IDX_W-1:0] REG_PROCESS_NOISE     = skf_pkg::REG_PROCESS_NOISE;
	localparam logic [REG_IDX_W-1:0] REG_MEASUREMENT_NOISE = skf_pkg::REG_MEASUREMENT_NOISE;
	localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = skf_pkg::PROCESS_NOISE_RST;
	localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = skf_pkg::MEASUREMENT_NOISE_RST;
	localparam logic [DATA_W-1:0] COVARIANCE_RST        = skf_pkg::COVARIANCE_RST;

	localparam int    RANDOM_SAMPLES = 550;
	localparam int    CYCLE_LIMIT    = 500000;
	localparam int    IDLE_PCT       = 29;
	localparam int    DRAIN_CYCLES   = 2 * FRAC_BITS + 10;
	localparam int    STEADY_FIRST   = 250;
	localparam int    STEADY_LAST    = 330;
	localparam int    DIR_ROWS       = 24;
	localparam longint MAX_GAIN      = (longint'(1) << FRAC_BITS) - 1;
	localparam longint EST_MAX       = 64'sh7FFF_FFFF;
	localparam longint EST_MIN       = -64'sh8000_0000;

	// indexes past the register list; writes there must be dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = REG_IDX_W'(3);

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [DATA_W-1:0] filtered;
		logic [DATA_W-1:0] cov;
	} estimate_pair_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [REG_IDX_W-1:0] idx;
		logic [DATA_W-1:0]    data;
		logic                 has_exp;
		estimate_pair_t       exp;
	} stim_row_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 sample_valid   = 1'b0;
	logic                 sample_ready;
	logic [DATA_W-1:0]    sample         = '0;
	logic                 result_valid;
	logic                 result_ready   = 1'b0;
	logic [DATA_W-1:0]    filtered;
	logic [DATA_W-1:0]    covariance_now;
	logic                 cfg_valid      = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index      = '0;
	logic [DATA_W-1:0]    cfg_data       = '0;

	// filter state as the block should hold it
	logic [DATA_W-1:0] est_q   = '0;
	logic [DATA_W-1:0] cov_q   = COVARIANCE_RST;
	logic [DATA_W-1:0] q_noise = PROCESS_NOISE_RST;
	logic [DATA_W-1:0] r_noise = MEASUREMENT_NOISE_RST;

	estimate_pair_t pending_estimates[$];
	stim_row_t      dir_rows [DIR_ROWS];

	int  mismatches    = 0;
	int  samples_sent  = 0;
	int  reg_writes    = 0;
	int  noise_phases  = 0;
	int  results_seen  = 0;
	int  cycle_count   = 0;
	bit  no_idle       = 1'b0;
	logic [DATA_W-1:0] last_sample = '0;

	scalar_kalman_filter_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample         (sample),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.filtered       (filtered),
		.covariance_now (covariance_now),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		logic [DATA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DATA_W] ? '1 : s[DATA_W-1:0];
	endfunction

	// advances the filter state by one measurement
	function automatic estimate_pair_t kalman_step(input logic [DATA_W-1:0] meas);
		logic [DATA_W-1:0] pp;
		logic [DATA_W-1:0] den;
		logic [63:0]       quot;
		logic [63:0]       gain;
		longint            diff;
		longint            nx;
		estimate_pair_t    r;
		pp = sat_sum(cov_q, q_noise);
		den = sat_sum(pp, r_noise);
		gain = '0;
		if (den != '0) begin
			quot = (64'(pp) << FRAC_BITS) / 64'(den);
			gain = (quot > 64'(MAX_GAIN)) ? 64'(MAX_GAIN) : quot;
		end
		diff = longint'($signed(meas)) - longint'($signed(est_q));
		nx = longint'($signed(est_q)) + ((longint'(gain) * diff) >>> FRAC_BITS);
		if (nx > EST_MAX)
			nx = EST_MAX;
		if (nx < EST_MIN)
			nx = EST_MIN;
		est_q = nx[DATA_W-1:0];
		cov_q = DATA_W'((((64'(1) << FRAC_BITS) - gain) * 64'(pp)) >> FRAC_BITS);
		r.filtered = est_q;
		r.cov = cov_q;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] pick_noise();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return DATA_W'(1);
			3: return DATA_W'($urandom_range(0, 1 << 12));
			4: return DATA_W'($urandom_range(0, 1 << 20));
			5: return DATA_W'($urandom);
			6: return ($urandom_range(0, 1)) ? PROCESS_NOISE_RST : MEASUREMENT_NOISE_RST;
			default: return DATA_W'($urandom_range(1 << 16, 1 << 24));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_sample();
		logic [DATA_W-1:0] ext [4];
		ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return DATA_W'($urandom);
			// near the current estimate, where the filter spends its life
			4, 5, 6, 7: return est_q + DATA_W'($urandom_range(0, 1 << 21)) - DATA_W'(1 << 20);
			8: return ext[$urandom_range(0, 3)];
			default: return last_sample;
		endcase
	endfunction

	task automatic send_sample(input logic [DATA_W-1:0] value, input logic has_exp,
		input estimate_pair_t typed);
		estimate_pair_t pred;
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		pred = kalman_step(value);
		pending_estimates.push_back(has_exp ? typed : pred);
		last_sample = value;
		samples_sent++;
	endtask

	// only issued with the filter idle; cfg_valid stays up when another write follows
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value,
		input bit more);
		sample_valid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (!more)
			cfg_valid <= 1'b0;
		case (idx)
			REG_PROCESS_NOISE:     q_noise = value;
			REG_MEASUREMENT_NOISE: r_noise = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	always @(posedge clk) begin : result_check
		estimate_pair_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (pending_estimates.size() == 0) begin
				$display("%0t: unexpected result: filtered %h covariance %h", $time,
					filtered, covariance_now);
				mismatches++;
			end else begin
				want = pending_estimates.pop_front();
				if (filtered !== want.filtered) begin
					$display("%0t: filtered mismatch: expected %h, got %h", $time,
						want.filtered, filtered);
					mismatches++;
				end
				if (covariance_now !== want.cov) begin
					$display("%0t: covariance mismatch: expected %h, got %h", $time,
						want.cov, covariance_now);
					mismatches++;
				end
			end
		end
		result_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d requests outstanding", $time,
				pending_estimates.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		int n_rand;
		int phase_len;
		int mask;
		bit more;

		// with both noises at zero the gain pins at its ceiling, then the divisor
		// collapses and the estimate freezes; a saturated Q pins the covariance
		dir_rows = '{
			'{ROW_CFG,    REG_PROCESS_NOISE,     32'h0000_0000, 1'b0, 64'h0},
			'{ROW_CFG,    REG_MEASUREMENT_NOISE, 32'h0000_0000, 1'b0, 64'h0},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h0001_0000, 1'b1,
				{32'h0000_FFFF, 32'h0000_0001}},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h0001_0000, 1'b1,
				{32'h0000_FFFF, 32'h0000_0000}},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h7FFF_FFFF, 1'b1,
				{32'h0000_FFFF, 32'h0000_0000}},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h8000_0000, 1'b1,
				{32'h0000_FFFF, 32'h0000_0000}},
			'{ROW_CFG,    REG_SPARE_A,           32'hFFFF_FFFF, 1'b0, 64'h0},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h0000_0000, 1'b1,
				{32'h0000_FFFF, 32'h0000_0000}},
			'{ROW_CFG,    REG_SPARE_B,           32'hFFFF_FFFF, 1'b0, 64'h0},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'hFFFF_FFFF, 1'b1,
				{32'h0000_FFFF, 32'h0000_0000}},
			'{ROW_CFG,    REG_PROCESS_NOISE,     32'hFFFF_FFFF, 1'b0, 64'h0},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h0000_0000, 1'b1,
				{32'h0000_0000, 32'h0000_FFFF}},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h7FFF_FFFF, 1'b0, 64'h0},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h8000_0000, 1'b0, 64'h0},
			'{ROW_CFG,    REG_PROCESS_NOISE,     32'h0000_0000, 1'b0, 64'h0},
			'{ROW_CFG,    REG_MEASUREMENT_NOISE, 32'hFFFF_FFFF, 1'b0, 64'h0},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h0001_0000, 1'b0, 64'h0},
			'{ROW_CFG,    REG_PROCESS_NOISE,     PROCESS_NOISE_RST, 1'b0, 64'h0},
			'{ROW_CFG,    REG_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RST, 1'b0, 64'h0},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h0000_0000, 1'b0, 64'h0},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'hFFFF_FFFF, 1'b0, 64'h0},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h0000_0001, 1'b0, 64'h0},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'h5555_5555, 1'b0, 64'h0},
			'{ROW_SAMPLE, REG_PROCESS_NOISE,     32'hAAAA_AAAA, 1'b0, 64'h0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				more = (i + 1 < DIR_ROWS) && (dir_rows[i + 1].kind == ROW_CFG);
				write_reg(dir_rows[i].idx, dir_rows[i].data, more);
			end else begin
				send_sample(dir_rows[i].data, dir_rows[i].has_exp, dir_rows[i].exp);
			end
		end

		n_rand = 0;
		while (n_rand < RANDOM_SAMPLES) begin
			mask = $urandom_range(1, 3);
			if ($urandom_range(0, 7) == 0)
				write_reg(($urandom_range(0, 1)) ? REG_SPARE_A : REG_SPARE_B,
					DATA_W'($urandom), 1'b1);
			if (mask[0])
				write_reg(REG_PROCESS_NOISE, pick_noise(), mask[1]);
			if (mask[1])
				write_reg(REG_MEASUREMENT_NOISE, pick_noise(), 1'b0);
			noise_phases++;
			phase_len = $urandom_range(15, 60);
			for (int k = 0; k < phase_len && n_rand < RANDOM_SAMPLES; k++) begin
				no_idle = (n_rand >= STEADY_FIRST) && (n_rand < STEADY_LAST);
				send_sample(pick_sample(), 1'b0, '0);
				n_rand++;
			end
		end
		no_idle = 1'b0;
		sample_valid <= 1'b0;

		while (pending_estimates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Filtered %0d samples (%0d results) across %0d noise settings, %0d reg writes",
			samples_sent, results_seen, noise_phases, reg_writes);
		$display("Mismatches: %0d, requests left outstanding: %0d", mismatches,
			pending_estimates.size());
		if (mismatches == 0 && pending_estimates.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
